// ===== hdl/dhrb_pkg.sv =====
package dhrb_pkg;

   localparam int DATA_W           = 16;
   localparam int IDX_W            = 13;
   localparam int SEG_W            = 3;
   localparam int CMD_W            = 3;
   localparam int WINDOW_WORDS_DEF = 8192;

   // command codes carried in tuser
   localparam logic [CMD_W-1:0] CMD_P0_WR    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_P1_WR    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_P1_RD    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_P3_WR    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_HOST_CTL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_HOST_WR  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_HOST_RD  = 3'd6;

   localparam logic [SEG_W-1:0]  SEG_RAM   = 3'd3;
   localparam logic [DATA_W-1:0] CTL_START = 16'h0000;
   localparam logic [DATA_W-1:0] CTL_STOP  = 16'h0001;

   // packed so that host_halt sits in the lowest bit
   typedef struct packed {
      logic dsp_bio;
      logic dsp_int;
      logic dsp_halt;
      logic host_halt;
   } status_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

endpackage

// ===== hdl/dhrb_ram.sv =====
module dhrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dhrb_ctrl.sv =====
module dhrb_ctrl #(
   parameter int WINDOW_WORDS = dhrb_pkg::WINDOW_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_acc,
   input  logic [dhrb_pkg::CMD_W-1:0]   cmd,
   input  logic [dhrb_pkg::DATA_W-1:0]  data,
   input  logic [dhrb_pkg::IDX_W-1:0]   host_word,
   output dhrb_pkg::mem_req_type        mem_req,
   output dhrb_pkg::status_type         status
);

   localparam logic [dhrb_pkg::IDX_W:0] WIN_LIM = (dhrb_pkg::IDX_W + 1)'(WINDOW_WORDS);

   logic [dhrb_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [dhrb_pkg::SEG_W-1:0] seg_ff, seg_in;
   logic                       run_ff, run_in;
   dhrb_pkg::status_type       stat_ff, stat_in;
   logic                       dsp_hit;
   logic                       host_hit;
   logic                       data_zero;

   assign dsp_hit   = (seg_ff == dhrb_pkg::SEG_RAM) && ({1'b0, idx_ff} < WIN_LIM);
   assign host_hit  = {1'b0, host_word} < WIN_LIM;
   assign data_zero = data == '0;

   always_comb begin
      idx_in        = idx_ff;
      seg_in        = seg_ff;
      run_in        = run_ff;
      stat_in       = stat_ff;
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.addr  = idx_ff;
      mem_req.wdata = data;
      if (req_acc) begin
         unique case (cmd)
            dhrb_pkg::CMD_P0_WR: begin
               idx_in = data[dhrb_pkg::IDX_W-1:0];
               seg_in = data[dhrb_pkg::DATA_W-1:dhrb_pkg::IDX_W];
            end
            dhrb_pkg::CMD_P1_WR: begin
               run_in = 1'b0;
               if (dsp_hit) begin
                  mem_req.we = 1'b1;
                  // a zero in word 0 or 1 arms the host release
                  if ((idx_ff[dhrb_pkg::IDX_W-1:1] == '0) && data_zero) begin
                     run_in = 1'b1;
                  end
               end
            end
            dhrb_pkg::CMD_P1_RD: begin
               mem_req.re = dsp_hit;
            end
            dhrb_pkg::CMD_P3_WR: begin
               if (data[dhrb_pkg::DATA_W-1]) begin
                  stat_in.dsp_bio = 1'b0;
               end
               if (data_zero) begin
                  if (run_ff) begin
                     stat_in.host_halt = 1'b0;
                     run_in            = 1'b0;
                  end
                  stat_in.dsp_bio = 1'b1;
               end
            end
            dhrb_pkg::CMD_HOST_CTL: begin
               if (data == dhrb_pkg::CTL_START) begin
                  stat_in.dsp_halt  = 1'b0;
                  stat_in.dsp_int   = 1'b1;
                  stat_in.host_halt = 1'b1;
               end else if (data == dhrb_pkg::CTL_STOP) begin
                  stat_in.dsp_int  = 1'b0;
                  stat_in.dsp_halt = 1'b1;
               end
            end
            dhrb_pkg::CMD_HOST_WR: begin
               mem_req.we   = host_hit;
               mem_req.addr = host_word;
            end
            dhrb_pkg::CMD_HOST_RD: begin
               mem_req.re   = host_hit;
               mem_req.addr = host_word;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff            <= '0;
         seg_ff            <= '0;
         run_ff            <= 1'b0;
         stat_ff.host_halt <= 1'b0;
         stat_ff.dsp_halt  <= 1'b1;
         stat_ff.dsp_int   <= 1'b0;
         stat_ff.dsp_bio   <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         seg_ff  <= seg_in;
         run_ff  <= run_in;
         stat_ff <= stat_in;
      end
   end

   assign status = stat_in;

endmodule

// ===== hdl/dsp_host_ram_bridge.sv =====
// channel | direction | bits                                | contents
// req_    | in        | tuser[2:0], tdata[31:0]             | cmd; data, host_word
// rsp_    | out       | tdata[23:0]                         | rdata, four status flags
//
// Sustains one beat per cycle while rsp_tready is high. Two stages: the accept
// edge updates control state, writes the RAM and launches its registered read;
// the output register then loads once it is free or drained, raising rsp_tvalid.
// Reset clears the control state (DSP held halted); RAM contents stay undefined.
// A stalled output holds its beat; the middle stage then fills and req_tready drops.
module dsp_host_ram_bridge #(
   parameter int WINDOW_WORDS = dhrb_pkg::WINDOW_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // cmd
   input  logic [31:0] req_tdata,   // data[15:0], host_word[28:16], zero[31:29]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // rdata[15:0], host_halt, dsp_halt,
                                    // dsp_interrupt, dsp_bio, zero[23:20]
);

   localparam int AW = $clog2(WINDOW_WORDS);

   logic                        req_acc;
   logic                        out_load;
   dhrb_pkg::mem_req_type       mem_req;
   dhrb_pkg::status_type        status;
   logic [dhrb_pkg::DATA_W-1:0] ram_q;

   logic                        s1_vld_ff, s1_vld_in;
   logic                        s1_re_ff;
   dhrb_pkg::status_type        s1_stat_ff;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [23:0]                 rsp_data_ff;
   logic [dhrb_pkg::DATA_W-1:0] rd_word;

   assign out_load   = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || out_load;
   assign req_acc    = req_tvalid && req_tready;

   dhrb_ctrl #(
      .WINDOW_WORDS (WINDOW_WORDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_acc   (req_acc),
      .cmd       (req_tuser),
      .data      (req_tdata[15:0]),
      .host_word (req_tdata[28:16]),
      .mem_req   (mem_req),
      .status    (status)
   );

   dhrb_ram #(
      .WIDTH (dhrb_pkg::DATA_W),
      .DEPTH (WINDOW_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.addr[AW-1:0]),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.re),
      .rd_addr (mem_req.addr[AW-1:0]),
      .rd_data (ram_q)
   );

   assign s1_vld_in  = req_acc || (s1_vld_ff && !out_load);
   assign rsp_vld_in = out_load || (rsp_vld_ff && !rsp_tready);
   assign rd_word    = s1_re_ff ? ram_q : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // ram_q holds while the stage is stalled since no new read is launched
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_re_ff   <= mem_req.re;
         s1_stat_ff <= status;
      end
      if (out_load) begin
         rsp_data_ff <= {4'b0000, s1_stat_ff, rd_word};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("middle stage accepted a beat while blocked");

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("RAM read and write launched by one beat");

   a_int_vs_halt: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (s1_stat_ff.dsp_int != s1_stat_ff.dsp_halt))
      else $error("DSP interrupt and halt out of step");

   a_no_access_idle: assert property (@(posedge clock) disable iff (reset)
      !req_acc |-> !(mem_req.we || mem_req.re))
      else $error("RAM access without an accepted beat");
`endif

endmodule

// ===== tb/sv/dhrb_checker.sv =====
`timescale 1ns / 100ps

module dhrb_checker #(
   parameter int WINDOW_WORDS = dhrb_pkg::WINDOW_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,   // cmd
   input  logic [31:0] req_tdata,   // data[15:0], host_word[28:16], zero[31:29]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // rdata[15:0], host_halt, dsp_halt,
                                    // dsp_interrupt, dsp_bio, zero[23:20]
   output int          fault_count,
   output int          outstanding
);

   typedef struct packed {
      logic [dhrb_pkg::DATA_W-1:0] rdata;
      dhrb_pkg::status_type        flags;
   } bridge_result_type;

   // mirror of the bridge state
   logic [dhrb_pkg::DATA_W-1:0] ram_mirror [WINDOW_WORDS];
   logic [dhrb_pkg::IDX_W-1:0]  ptr_index;
   logic [dhrb_pkg::SEG_W-1:0]  ptr_segment;
   logic                        run_flag;
   dhrb_pkg::status_type        line_state;

   bridge_result_type           awaited_results [$];

   function automatic bit in_window(input logic [dhrb_pkg::IDX_W-1:0] idx);
      return int'(idx) < WINDOW_WORDS;
   endfunction

   function automatic bridge_result_type predict_bridge_beat(
         input logic [dhrb_pkg::CMD_W-1:0]  op,
         input logic [dhrb_pkg::DATA_W-1:0] word,
         input logic [dhrb_pkg::IDX_W-1:0]  hidx);
      bridge_result_type res;
      res.rdata = '0;
      case (op)
         dhrb_pkg::CMD_P0_WR: begin
            ptr_index   = word[dhrb_pkg::IDX_W-1:0];
            ptr_segment = word[dhrb_pkg::DATA_W-1:dhrb_pkg::IDX_W];
         end
         dhrb_pkg::CMD_P1_WR: begin
            run_flag = 1'b0;
            if (ptr_segment == dhrb_pkg::SEG_RAM && in_window(ptr_index)) begin
               ram_mirror[ptr_index] = word;
               // a zero into either of the first two words arms the host release
               if (ptr_index < 2 && word == '0)
                  run_flag = 1'b1;
            end
         end
         dhrb_pkg::CMD_P1_RD: begin
            if (ptr_segment == dhrb_pkg::SEG_RAM && in_window(ptr_index))
               res.rdata = ram_mirror[ptr_index];
         end
         dhrb_pkg::CMD_P3_WR: begin
            if (word[dhrb_pkg::DATA_W-1])
               line_state.dsp_bio = 1'b0;
            if (word == '0) begin
               if (run_flag) begin
                  line_state.host_halt = 1'b0;
                  run_flag = 1'b0;
               end
               line_state.dsp_bio = 1'b1;
            end
         end
         dhrb_pkg::CMD_HOST_CTL: begin
            if (word == dhrb_pkg::CTL_START) begin
               line_state.dsp_halt  = 1'b0;
               line_state.dsp_int   = 1'b1;
               line_state.host_halt = 1'b1;
            end else if (word == dhrb_pkg::CTL_STOP) begin
               line_state.dsp_int  = 1'b0;
               line_state.dsp_halt = 1'b1;
            end
         end
         dhrb_pkg::CMD_HOST_WR: begin
            if (in_window(hidx))
               ram_mirror[hidx] = word;
         end
         dhrb_pkg::CMD_HOST_RD: begin
            if (in_window(hidx))
               res.rdata = ram_mirror[hidx];
         end
         default: ;
      endcase
      res.flags = line_state;
      return res;
   endfunction

   task automatic report_error(input string field, input int got, input int want);
      fault_count++;
      if (fault_count <= 40)
         $display("ERROR at %0t: %s is 0x%0h, predicted 0x%0h", $time, field, got, want);
   endtask

   always @(posedge clock) begin : watch
      bridge_result_type    want;
      dhrb_pkg::status_type seen;
      if (reset) begin
         ptr_index   = '0;
         ptr_segment = '0;
         run_flag    = 1'b0;
         line_state  = '{dsp_bio: 1'b0, dsp_int: 1'b0, dsp_halt: 1'b1, host_halt: 1'b0};
         awaited_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_error("unexpected response beat", int'(rsp_tdata), 0);
            end else begin
               want = awaited_results.pop_front();
               seen = rsp_tdata[19:16];
               if (rsp_tdata[15:0] != want.rdata)
                  report_error("rdata", int'(rsp_tdata[15:0]), int'(want.rdata));
               if (seen.host_halt != want.flags.host_halt)
                  report_error("host_halt", int'(seen.host_halt),
                               int'(want.flags.host_halt));
               if (seen.dsp_halt != want.flags.dsp_halt)
                  report_error("dsp_halt", int'(seen.dsp_halt), int'(want.flags.dsp_halt));
               if (seen.dsp_int != want.flags.dsp_int)
                  report_error("dsp_interrupt", int'(seen.dsp_int),
                               int'(want.flags.dsp_int));
               if (seen.dsp_bio != want.flags.dsp_bio)
                  report_error("dsp_bio", int'(seen.dsp_bio), int'(want.flags.dsp_bio));
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(predict_bridge_beat(req_tuser, req_tdata[15:0],
                                                          req_tdata[28:16]));
         outstanding <= awaited_results.size();
      end
   end

endmodule

// ===== tb/sv/tb_dsp_host_ram_bridge.sv =====
`timescale 1ns / 100ps

module tb_dsp_host_ram_bridge;

   localparam logic [dhrb_pkg::CMD_W-1:0] CMD_UNUSED  = 3'd7;
   localparam int                         BEAT_TARGET = 1900;
   localparam int                         CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   int          fault_count;
   int          outstanding;
   int          cycle_count;
   int          beats_sent;
   int          stall_left;
   bit          steady;
   bit          paused;

   // stimulus-side view of what the RAM holds, so no read lands on an unwritten word
   bit                         written [dhrb_pkg::WINDOW_WORDS_DEF];
   int                         written_list [$];
   logic [dhrb_pkg::IDX_W-1:0] shadow_index;
   logic [dhrb_pkg::SEG_W-1:0] shadow_segment;

   dsp_host_ram_bridge u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dhrb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // output backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void note_write(input logic [dhrb_pkg::IDX_W-1:0] idx);
      if (!written[idx]) begin
         written[idx] = 1'b1;
         written_list.push_back(int'(idx));
      end
   endfunction

   function automatic logic [dhrb_pkg::IDX_W-1:0] pick_written();
      return 13'(written_list[$urandom_range(0, written_list.size() - 1)]);
   endfunction

   task automatic send_beat(input logic [dhrb_pkg::CMD_W-1:0]  op,
                            input logic [dhrb_pkg::DATA_W-1:0] word,
                            input logic [dhrb_pkg::IDX_W-1:0]  hidx);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, hidx, word};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      case (op)
         dhrb_pkg::CMD_P0_WR: begin
            shadow_index   = word[dhrb_pkg::IDX_W-1:0];
            shadow_segment = word[dhrb_pkg::DATA_W-1:dhrb_pkg::IDX_W];
         end
         dhrb_pkg::CMD_P1_WR: if (shadow_segment == dhrb_pkg::SEG_RAM) note_write(shadow_index);
         dhrb_pkg::CMD_HOST_WR: note_write(hidx);
         default: ;
      endcase
   endtask

   // host start, arm through word 0 or 1, then release from port 3; sometimes broken
   task automatic run_release_sequence();
      logic [dhrb_pkg::IDX_W-1:0] slot;
      slot = 13'($urandom_range(0, 1));
      send_beat(dhrb_pkg::CMD_HOST_CTL, dhrb_pkg::CTL_START, 13'($urandom));
      send_beat(dhrb_pkg::CMD_P0_WR, {dhrb_pkg::SEG_RAM, slot}, 13'($urandom));
      send_beat(dhrb_pkg::CMD_P1_WR,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0000, 13'($urandom));
      if ($urandom_range(0, 3) == 0)
         send_beat(dhrb_pkg::CMD_P1_RD, 16'($urandom), 13'($urandom));
      if ($urandom_range(0, 4) == 0)
         send_beat(dhrb_pkg::CMD_HOST_RD, 16'($urandom), pick_written());
      send_beat(dhrb_pkg::CMD_P3_WR,
                ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'h0000, 13'($urandom));
      if ($urandom_range(0, 2) == 0)
         send_beat(dhrb_pkg::CMD_HOST_CTL, dhrb_pkg::CTL_STOP, 13'($urandom));
   endtask

   task automatic send_random_op();
      int                          r;
      int                          m;
      logic [dhrb_pkg::DATA_W-1:0] word;
      logic [dhrb_pkg::IDX_W-1:0]  idx;
      r = $urandom_range(0, 99);
      m = $urandom_range(0, 99);
      word = 16'($urandom);
      if (r < 12) begin
         if (m < 50) begin
            if (m < 20)
               idx = pick_written();
            else if (m < 35)
               idx = 13'($urandom_range(0, 3));
            else
               idx = 13'($urandom);
            word = {dhrb_pkg::SEG_RAM, idx};
         end
         send_beat(dhrb_pkg::CMD_P0_WR, word, 13'($urandom));
      end else if (r < 30) begin
         if (m < 25)
            word = 16'h0000;
         else if (m < 35)
            word = 16'hffff;
         send_beat(dhrb_pkg::CMD_P1_WR, word, 13'($urandom));
      end else if (r < 45) begin
         // a read of an unwritten word is not allowed: write it instead
         if (shadow_segment == dhrb_pkg::SEG_RAM && !written[shadow_index])
            send_beat(dhrb_pkg::CMD_P1_WR, word, 13'($urandom));
         else
            send_beat(dhrb_pkg::CMD_P1_RD, word, 13'($urandom));
      end else if (r < 55) begin
         if (m < 40)
            word = 16'h0000;
         else if (m < 70)
            word[15] = 1'b1;
         send_beat(dhrb_pkg::CMD_P3_WR, word, 13'($urandom));
      end else if (r < 62) begin
         if (m < 40)
            word = dhrb_pkg::CTL_START;
         else if (m < 80)
            word = dhrb_pkg::CTL_STOP;
         send_beat(dhrb_pkg::CMD_HOST_CTL, word, 13'($urandom));
      end else if (r < 78) begin
         idx = (m < 50) ? 13'($urandom) : 13'($urandom_range(0, 15));
         send_beat(dhrb_pkg::CMD_HOST_WR, word, idx);
      end else if (r < 95) begin
         send_beat(dhrb_pkg::CMD_HOST_RD, word, pick_written());
      end else begin
         send_beat(CMD_UNUSED, word, 13'($urandom));
      end
   endtask

   initial begin
      shadow_index   = '0;
      shadow_segment = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: window extremes, segments, control values, release path
      send_beat(dhrb_pkg::CMD_P1_RD, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_WR, 16'hffff, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_RD, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_WR, 16'h0000, 13'h1fff);
      send_beat(dhrb_pkg::CMD_HOST_RD, 16'hffff, 13'h1fff);
      send_beat(dhrb_pkg::CMD_P0_WR, 16'h7fff, 13'h1fff);
      send_beat(dhrb_pkg::CMD_P1_WR, 16'ha5c3, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_RD, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P0_WR, 16'he000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_WR, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_RD, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_CTL, dhrb_pkg::CTL_START, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_CTL, 16'h0002, 13'h0000);
      send_beat(dhrb_pkg::CMD_P0_WR, 16'h6000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_WR, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P3_WR, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P3_WR, 16'h8000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P3_WR, 16'h1234, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_CTL, dhrb_pkg::CTL_START, 13'h0000);
      send_beat(dhrb_pkg::CMD_P0_WR, 16'h6001, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_WR, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_P1_WR, 16'h0005, 13'h0000);
      send_beat(dhrb_pkg::CMD_P3_WR, 16'h0000, 13'h0000);
      send_beat(dhrb_pkg::CMD_HOST_CTL, dhrb_pkg::CTL_STOP, 13'h0000);
      send_beat(CMD_UNUSED, 16'hffff, 13'h1fff);

      while (beats_sent < BEAT_TARGET) begin
         steady = ((beats_sent / 128) % 5) == 3;
         if (!paused && beats_sent >= BEAT_TARGET / 2) begin
            // drain the bridge completely once
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if ($urandom_range(0, 99) < 12)
            run_release_sequence();
         else
            send_random_op();
      end

      steady = 1'b0;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/dhrb_pkg.sv
hdl/dhrb_ram.sv
hdl/dhrb_ctrl.sv
hdl/dsp_host_ram_bridge.sv
tb/sv/dhrb_checker.sv
tb/sv/tb_dsp_host_ram_bridge.sv
